// File: src/stcd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stcd_pkg: shared types and constants of the seconds to calendar date unit
// controller states, command and status bundles, calendar constants and the
// leap-year and month-length helpers
// ----------------------------------------------------------------------------
package stcd_pkg;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_REM,
        ST_YEAR,
        ST_MONTH,
        ST_DONE
    } t_state;

    // which constant divide the shared divide-by-constant unit performs
    typedef enum logic [1:0] {
        DIV_SEC,
        DIV_MIN,
        DIV_HOUR
    } t_div_sel;

    // controller to datapath commands
    typedef struct packed {
        logic     load;
        logic     mul_en;
        logic     rem_en;
        t_div_sel div_sel;
        logic     year_step;
        logic     month_step;
        logic     out_load;
    } t_ctrl_cmd;

    // datapath to controller status
    typedef struct packed {
        logic year_more;
        logic month_stop;
    } t_dp_status;

    localparam int EPOCH_W = 32;
    localparam int DAYS_W  = 16;
    localparam int YEAR_W  = 8;
    localparam int MIDX_W  = 4;

    // reciprocal constants: floor(n * magic >> shift) is exact for any 32-bit n
    localparam logic [31:0] MAGIC_60 = 32'h8888_8889;
    localparam int          SHIFT_60 = 37;
    localparam logic [31:0] MAGIC_24 = 32'hAAAA_AAAB;
    localparam int          SHIFT_24 = 36;

    localparam logic [5:0]  SEC_PER_MIN   = 6'd60;
    localparam logic [4:0]  HOURS_PER_DAY = 5'd24;

    localparam logic [8:0]  DAYS_COMMON_YEAR = 9'd365;
    localparam logic [8:0]  DAYS_LEAP_YEAR   = 9'd366;
    localparam logic [4:0]  DAYS_FEB_LEAP    = 5'd29;

    localparam logic [YEAR_W-1:0] MAX_YEAR_STEPS = 8'd255;
    // offsets of the century years 2100 and 2200, not leap years
    localparam logic [YEAR_W-1:0] OFFSET_2100    = 8'd100;
    localparam logic [YEAR_W-1:0] OFFSET_2200    = 8'd200;

    localparam logic [MIDX_W-1:0] MONTH_FEB  = 4'd1;
    localparam logic [MIDX_W-1:0] MONTH_DEC  = 4'd11;

    // gregorian leap rule on 2000 plus offset, for offsets 0 to 255
    function automatic logic is_leap(input logic [YEAR_W-1:0] offset);
        return (offset[1:0] == 2'b00) && (offset != OFFSET_2100)
            && (offset != OFFSET_2200);
    endfunction

    // month length, february taking the leap flag into account
    function automatic logic [4:0] month_length(input logic [MIDX_W-1:0] idx,
                                                input logic leap);
        logic [4:0] len;
        unique case (idx)
            MONTH_FEB: len = leap ? DAYS_FEB_LEAP : 5'd28;
            4'd3:      len = 5'd30;
            4'd5:      len = 5'd30;
            4'd8:      len = 5'd30;
            4'd10:     len = 5'd30;
            default:   len = 5'd31;
        endcase
        return len;
    endfunction

endpackage
`default_nettype wire

// File: src/stcd_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stcd_datapath: working registers of the date conversion
// shared divide-by-constant unit, year walk, month walk and result registers
// ----------------------------------------------------------------------------
module stcd_datapath
    import stcd_pkg::*;
(
    input  wire  logic                i_clk,
    input  wire  t_ctrl_cmd           i_cmd,
    output t_dp_status                o_status,
    input  wire  logic [EPOCH_W-1:0]  i_epoch_seconds,
    output logic [5:0]                o_second_of_minute,
    output logic [5:0]                o_minute_of_hour,
    output logic [4:0]                o_hour_of_day,
    output logic [7:0]                o_year_offset,
    output logic [3:0]                o_month_number,
    output logic [4:0]                o_day_of_month
);

    logic [EPOCH_W-1:0]   r_num;
    logic [2*EPOCH_W-1:0] r_prod;
    logic [5:0]           r_sec;
    logic [5:0]           r_min;
    logic [4:0]           r_hour;
    logic [DAYS_W-1:0]    r_days;
    logic [YEAR_W-1:0]    r_year;
    logic [MIDX_W-1:0]    r_month;

    logic [EPOCH_W-1:0]   mul_magic;
    logic [EPOCH_W-1:0]   quo;
    logic [EPOCH_W-1:0]   rem;
    logic                 leap;
    logic [8:0]           year_len;
    logic [4:0]           month_len;
    logic                 month_fits;

    // reciprocal multiply, then quotient and remainder from the registered product
    always_comb begin
        unique case (i_cmd.div_sel)
            DIV_HOUR: begin
                mul_magic = MAGIC_24;
                quo       = EPOCH_W'(r_prod >> SHIFT_24);
                rem       = r_num - quo * EPOCH_W'(HOURS_PER_DAY);
            end
            default: begin
                mul_magic = MAGIC_60;
                quo       = EPOCH_W'(r_prod >> SHIFT_60);
                rem       = r_num - quo * EPOCH_W'(SEC_PER_MIN);
            end
        endcase
    end

    assign leap       = is_leap(r_year);
    assign year_len   = leap ? DAYS_LEAP_YEAR : DAYS_COMMON_YEAR;
    assign month_len  = month_length(r_month, leap);
    assign month_fits = r_days >= DAYS_W'(month_len);

    assign o_status.year_more  = (r_days >= DAYS_W'(year_len)) && (r_year != MAX_YEAR_STEPS);
    assign o_status.month_stop = !month_fits || (r_month == MONTH_DEC);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_num   <= i_epoch_seconds;
            r_year  <= '0;
            r_month <= '0;
        end
        if (i_cmd.mul_en) begin
            r_prod <= (2*EPOCH_W)'(r_num) * (2*EPOCH_W)'(mul_magic);
        end
        if (i_cmd.rem_en) begin
            unique case (i_cmd.div_sel)
                DIV_SEC: begin
                    r_sec <= rem[5:0];
                    r_num <= quo;
                end
                DIV_MIN: begin
                    r_min <= rem[5:0];
                    r_num <= quo;
                end
                default: begin
                    r_hour <= rem[4:0];
                    r_days <= quo[DAYS_W-1:0];
                end
            endcase
        end
        if (i_cmd.year_step) begin
            r_days <= r_days - DAYS_W'(year_len);
            r_year <= r_year + 1'b1;
        end
        if (i_cmd.month_step && month_fits) begin
            r_days <= r_days - DAYS_W'(month_len);
            if (r_month != MONTH_DEC) begin
                r_month <= r_month + 1'b1;
            end
        end
        if (i_cmd.out_load) begin
            o_second_of_minute <= r_sec;
            o_minute_of_hour   <= r_min;
            o_hour_of_day      <= r_hour;
            o_year_offset      <= r_year;
            o_month_number     <= r_month + 1'b1;
            o_day_of_month     <= 5'(r_days + 1'b1);
        end
    end

endmodule
`default_nettype wire

// File: src/stcd_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stcd_ctrl: sequencer of the date conversion
// steps the three constant divides, the year walk and the month walk, and
// owns the input and output handshakes
// ----------------------------------------------------------------------------
module stcd_ctrl
    import stcd_pkg::*;
(
    input  wire  logic       i_clk,
    input  wire  logic       i_rst_n,
    input  wire  logic       i_valid,
    output logic             o_stall,
    output logic             o_valid,
    input  wire  logic       i_stall,
    output t_ctrl_cmd        o_cmd,
    input  wire  t_dp_status i_status
);

    t_state   r_state, n_state;
    t_div_sel r_div_sel, n_div_sel;
    logic     r_out_valid, n_out_valid;
    logic     out_free;

    assign out_free = !r_out_valid || !i_stall;
    assign o_stall  = (r_state != ST_IDLE);
    assign o_valid  = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_div_sel   <= DIV_SEC;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_div_sel   <= n_div_sel;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state        = r_state;
        n_div_sel      = r_div_sel;
        o_cmd          = '0;
        o_cmd.div_sel  = r_div_sel;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_div_sel  = DIV_SEC;
                    n_state    = ST_MUL;
                end
            end
            ST_MUL: begin
                o_cmd.mul_en = 1'b1;
                n_state      = ST_REM;
            end
            ST_REM: begin
                o_cmd.rem_en = 1'b1;
                unique case (r_div_sel)
                    DIV_SEC: begin
                        n_div_sel = DIV_MIN;
                        n_state   = ST_MUL;
                    end
                    DIV_MIN: begin
                        n_div_sel = DIV_HOUR;
                        n_state   = ST_MUL;
                    end
                    default: begin
                        n_state = ST_YEAR;
                    end
                endcase
            end
            ST_YEAR: begin
                if (i_status.year_more) begin
                    o_cmd.year_step = 1'b1;
                end else begin
                    n_state = ST_MONTH;
                end
            end
            ST_MONTH: begin
                o_cmd.month_step = 1'b1;
                if (i_status.month_stop) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // an accepted transaction starts the first multiply
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state == ST_MUL))
        else $error("accepted transaction did not start the divide");

    // the result register is only overwritten once the previous result is gone
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || !i_stall))
        else $error("result overwritten while still pending");

    // year walk leaves for the month walk once no whole year remains
    a_year_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_YEAR && !i_status.year_more) |=> (r_state == ST_MONTH))
        else $error("year walk did not hand over to month walk");

    // a stalled result stays valid until taken
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |=> r_out_valid)
        else $error("pending result dropped");

endmodule
`default_nettype wire

// File: src/seconds_to_calendar_date_unit.sv
`default_nettype none
// sequence: an accepted transaction runs the three constant divides (multiply, then
//   remainder), one year walk step per whole year, the month walk, and loads the
//   result once the result register is free
// a new transaction is taken only once the sequencer has returned to idle
// reset: synchronous active-low, returns the sequencer to idle and drops o_valid
// ----------------------------------------------------------------------------
// seconds_to_calendar_date_unit: epoch seconds to gregorian date and time
// splits seconds since 2000-01-01 00:00:00 into time of day, year offset,
// month and day of month
// ----------------------------------------------------------------------------
module seconds_to_calendar_date_unit
    import stcd_pkg::*;
(
    input  wire  logic        i_clk,
    input  wire  logic        i_rst_n,
    // input channel
    input  wire  logic        i_valid,
    output logic              o_stall,
    input  wire  logic [31:0] i_epoch_seconds,
    // result channel
    output logic              o_valid,
    input  wire  logic        i_stall,
    output logic [5:0]        o_second_of_minute,
    output logic [5:0]        o_minute_of_hour,
    output logic [4:0]        o_hour_of_day,
    output logic [7:0]        o_year_offset,
    output logic [3:0]        o_month_number,
    output logic [4:0]        o_day_of_month
);

    // command and status bundles between sequencer and datapath
    t_ctrl_cmd  cmd;
    t_dp_status status;

    // sequencer: divides, year walk, month walk, result handshake
    // new transactions are taken whenever it is idle, even with a result pending
    stcd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_cmd    (cmd),
        .i_status (status)
    );

    // datapath: reciprocal-multiply divider, day counters and result register
    stcd_datapath u_datapath (
        .i_clk              (i_clk),
        .i_cmd              (cmd),
        .o_status           (status),
        .i_epoch_seconds    (i_epoch_seconds),
        .o_second_of_minute (o_second_of_minute),
        .o_minute_of_hour   (o_minute_of_hour),
        .o_hour_of_day      (o_hour_of_day),
        .o_year_offset      (o_year_offset),
        .o_month_number     (o_month_number),
        .o_day_of_month     (o_day_of_month)
    );

endmodule
`default_nettype wire
